@@ rtl/qpbe_pkg.sv @@
package qpbe_pkg;

    localparam int FRAME_CELLS = 11;
    localparam int PRE_W = 5;
    localparam logic [PRE_W-1:0] PREAMBLE_RESET = 5'd15;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRE,
        PH_DATA,
        PH_CSUM
    } t_phase;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic bit_val;
        logic tail;
    } t_cell_data;

    // Start bit first, then data LSB first, odd parity, stop bit.
    function automatic logic [FRAME_CELLS-1:0] frame_of(input logic [7:0] byte_val);
        frame_of = {1'b1, ~(^byte_val), byte_val, 1'b0};
    endfunction

endpackage

@@ rtl/qi_packet_biphase_encoder.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         i_data_byte, i_first_byte, i_last_byte
// output    out        o_valid / i_ready         o_first_half_level, o_second_half_level,
//                                                o_end_of_run
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (preamble length)
//
// One bit cell leaves per cycle from an eleven-cell shift chain unless the output
// stalls. A byte is eleven cells, after preamble-length cells on a first byte and
// before eleven checksum cells on a last one. The next item is taken in the cycle
// the chain emits its final cell. Reset is synchronous and clears the phase, line
// level and checksum. An output stall freezes the chain and the output register.
module qi_packet_biphase_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_first_byte,
    input  logic                        i_last_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_first_half_level,
    output logic                        o_second_half_level,
    output logic                        o_end_of_run,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [qpbe_pkg::PRE_W-1:0]  i_cfg_data
);
    import qpbe_pkg::*;

    t_phase           r_phase, n_phase;
    logic [PRE_W-1:0] r_preamble;
    logic [PRE_W-1:0] r_pre_cnt, n_pre_cnt;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic             r_level, n_level;
    logic [7:0]       r_csum, n_csum;
    logic             r_out_valid, n_out_valid;
    logic             r_out_first, n_out_first;
    logic             r_out_second, n_out_second;
    logic             r_out_end, n_out_end;

    logic             w_adv;
    logic             w_accept;
    logic             w_load_data;
    logic             w_load_csum;
    logic             w_from_in;
    logic             w_data_first;
    logic             w_shift;
    logic [7:0]       w_byte_sel;
    logic [FRAME_CELLS-1:0] w_frame;
    t_cell_ctl        w_ctl;
    t_cell_data       w_head;

    assign w_adv = !r_out_valid || i_ready;
    assign o_ready = (r_phase == PH_IDLE) ||
                     (w_adv && w_head.tail &&
                      (((r_phase == PH_DATA) && !r_last) || (r_phase == PH_CSUM)));
    assign w_accept = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign w_byte_sel = w_from_in ? i_data_byte : r_byte;
    assign w_frame    = w_load_csum ? frame_of(r_csum) : frame_of(w_byte_sel);
    assign w_ctl.load  = w_load_data || w_load_csum;
    assign w_ctl.shift = w_shift;

    qpbe_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_frame (w_frame),
        .o_head  (w_head)
    );

    always_comb begin
        n_phase      = r_phase;
        n_pre_cnt    = r_pre_cnt;
        n_byte       = r_byte;
        n_last       = r_last;
        n_level      = r_level;
        n_csum       = r_csum;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_end    = r_out_end;
        w_load_data  = 1'b0;
        w_load_csum  = 1'b0;
        w_from_in    = 1'b0;
        w_data_first = 1'b0;
        w_shift      = 1'b0;

        case (r_phase)
            PH_PRE: begin
                if (w_adv) begin
                    n_out_valid  = 1'b1;
                    n_out_first  = 1'b1;
                    n_out_second = 1'b0;
                    n_out_end    = 1'b0;
                    if (r_pre_cnt == PRE_W'(1)) begin
                        w_load_data  = 1'b1;
                        w_data_first = 1'b1;
                        n_phase      = PH_DATA;
                    end else begin
                        n_pre_cnt = r_pre_cnt - PRE_W'(1);
                    end
                end
            end
            PH_DATA, PH_CSUM: begin
                if (w_adv) begin
                    w_shift      = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_first  = !r_level;
                    n_out_second = w_head.bit_val ? r_level : !r_level;
                    n_level      = n_out_second;
                    n_out_end    = w_head.tail && ((r_phase == PH_CSUM) || !r_last);
                    if (w_head.tail) begin
                        if ((r_phase == PH_DATA) && r_last) begin
                            w_load_csum = 1'b1;
                            n_phase     = PH_CSUM;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_accept) begin
            n_byte = i_data_byte;
            n_last = i_last_byte;
            if (i_first_byte && (r_preamble != '0)) begin
                n_phase   = PH_PRE;
                n_pre_cnt = r_preamble;
            end else begin
                w_load_data  = 1'b1;
                w_from_in    = 1'b1;
                w_data_first = i_first_byte;
                n_phase      = PH_DATA;
            end
        end

        if (w_load_data) begin
            n_csum = (w_data_first ? 8'h00 : r_csum) ^ (w_from_in ? i_data_byte : r_byte);
            if (w_data_first) begin
                n_level = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_preamble  <= PREAMBLE_RESET;
            r_pre_cnt   <= '0;
            r_last      <= 1'b0;
            r_level     <= 1'b0;
            r_csum      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pre_cnt   <= n_pre_cnt;
            r_last      <= n_last;
            r_level     <= n_level;
            r_csum      <= n_csum;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_preamble <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_end    <= n_out_end;
    end

    assign o_valid             = r_out_valid;
    assign o_first_half_level  = r_out_first;
    assign o_second_half_level = r_out_second;
    assign o_end_of_run        = r_out_end;

    a_pre_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRE) |-> (r_pre_cnt != '0))
        else $error("preamble phase with zero count");

    a_accept_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_phase != PH_IDLE)) |-> (w_head.tail && w_adv))
        else $error("item taken while a frame is still in the chain");

    a_idle_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_IDLE) && r_out_valid) |-> r_out_end)
        else $error("idle with a pending cell that does not end a run");

endmodule

@@ rtl/qpbe_cell.sv @@
module qpbe_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qpbe_pkg::t_cell_ctl  i_ctl,
    input  qpbe_pkg::t_cell_data i_load,
    input  qpbe_pkg::t_cell_data i_next,
    output qpbe_pkg::t_cell_data o_cell
);
    import qpbe_pkg::*;

    logic r_bit;
    logic r_tail;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bit <= i_load.bit_val;
        end else if (i_ctl.shift) begin
            r_bit <= i_next.bit_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 1'b0;
        end else if (i_ctl.load) begin
            r_tail <= i_load.tail;
        end else if (i_ctl.shift) begin
            r_tail <= i_next.tail;
        end
    end

    assign o_cell.bit_val = r_bit;
    assign o_cell.tail    = r_tail;

endmodule

@@ rtl/qpbe_chain.sv @@
module qpbe_chain (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qpbe_pkg::t_cell_ctl                  i_ctl,
    input  logic [qpbe_pkg::FRAME_CELLS-1:0]     i_frame,
    output qpbe_pkg::t_cell_data                 o_head
);
    import qpbe_pkg::*;

    t_cell_data w_cells [FRAME_CELLS+1];
    t_cell_data w_load  [FRAME_CELLS];

    assign w_cells[FRAME_CELLS] = '{bit_val: 1'b0, tail: 1'b0};

    for (genvar g = 0; g < FRAME_CELLS; g++) begin : g_cell
        assign w_load[g].bit_val = i_frame[g];
        assign w_load[g].tail    = (g == FRAME_CELLS - 1);

        qpbe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_load  (w_load[g]),
            .i_next  (w_cells[g+1]),
            .o_cell  (w_cells[g])
        );
    end

    assign o_head = w_cells[0];

endmodule

@@ test/qi_packet_biphase_encoder_tb.sv @@
module qi_packet_biphase_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpbe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic first_half;
        logic second_half;
        logic run_end;
    } t_cell;

    class cell_scoreboard;
        t_cell             pending_cells[$];
        logic              line_lvl;
        logic [7:0]        xor_sum;
        logic [PRE_W-1:0]  preamble_len;
        int unsigned       mismatches;

        function new();
            line_lvl = 1'b0;
            xor_sum = 8'h00;
            preamble_len = PREAMBLE_RESET;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return pending_cells.size();
        endfunction

        function void push_cell(logic a, logic b);
            t_cell c;
            c.first_half = a;
            c.second_half = b;
            c.run_end = 1'b0;
            pending_cells.push_back(c);
        endfunction

        function void code_cell(logic bit_val);
            logic a;
            line_lvl = ~line_lvl;
            a = line_lvl;
            if (bit_val) begin
                line_lvl = ~line_lvl;
            end
            push_cell(a, line_lvl);
        endfunction

        function void code_byte(logic [7:0] value);
            code_cell(1'b0);
            for (int k = 0; k < 8; k++) begin
                code_cell(value[k]);
            end
            code_cell(~(^value));
            code_cell(1'b1);
        endfunction

        // Works out every bit cell that one accepted item produces.
        function void note_byte(logic [7:0] data, logic first, logic last);
            if (first) begin
                for (int k = 0; k < preamble_len; k++) begin
                    push_cell(1'b1, 1'b0);
                end
                line_lvl = 1'b0;
                xor_sum = 8'h00;
            end
            code_byte(data);
            xor_sum = xor_sum ^ data;
            if (last) begin
                code_byte(xor_sum);
            end
            pending_cells[pending_cells.size() - 1].run_end = 1'b1;
        endfunction

        function void check_cell(logic fh, logic sh, logic eor);
            t_cell want;
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected cell: halves %b%b end %b", fh, sh, eor);
                end
            end else begin
                want = pending_cells.pop_front();
                if (want.first_half !== fh || want.second_half !== sh
                        || want.run_end !== eor) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("cell mismatch: expected halves %b%b end %b, got %b%b end %b",
                                 want.first_half, want.second_half, want.run_end,
                                 fh, sh, eor);
                    end
                end
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_first_byte = 1'b0;
    logic             i_last_byte = 1'b0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic             o_first_half_level;
    logic             o_second_half_level;
    logic             o_end_of_run;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [PRE_W-1:0] i_cfg_data = '0;

    cell_scoreboard   sb;
    bit               calm = 1'b0;
    int unsigned      rx_hold = 0;
    int unsigned      cycles = 0;

    qi_packet_biphase_encoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_first_byte        (i_first_byte),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_first_half_level  (o_first_half_level),
        .o_second_half_level (o_second_half_level),
        .o_end_of_run        (o_end_of_run),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_cell(o_first_half_level, o_second_half_level, o_end_of_run);
        end
    end

    initial begin : rx_drive
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 4);
            if (rx_hold != 0) begin
                gap = rx_hold;
                rx_hold = 0;
            end
            if (gap != 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_first_byte <= first;
        i_last_byte <= last;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        sb.note_byte(data, first, last);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_preamble(input logic [PRE_W-1:0] len);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        sb.preamble_len = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed packets of one to six bytes, with some items whose
    // first and last marks are random.
    task automatic random_traffic(input int unsigned count);
        int unsigned done;
        int unsigned len;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_byte(8'($urandom_range(0, 255)), k == 0, k == len - 1);
                end
                done += len;
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                done++;
            end
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b1);
        send_byte(8'hF0, 1'b1, 1'b0);
        send_byte(8'h0F, 1'b1, 1'b1);
        send_byte(8'h7E, 1'b0, 1'b0);
        send_byte(8'h81, 1'b1, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);

        write_preamble(5'd31);
        send_byte(8'hA5, 1'b1, 1'b1);
        random_traffic(60);

        write_preamble(5'd0);
        send_byte(8'h5A, 1'b1, 1'b1);
        random_traffic(35);
        wait_idle();
        random_traffic(35);

        write_preamble(5'd11);
        calm = 1'b1;
        random_traffic(60);
        calm = 1'b0;

        write_preamble(5'd25);
        rx_hold = 300;
        random_traffic(70);

        write_preamble(PRE_W'($urandom_range(0, 31)));
        random_traffic(80);

        write_preamble(PREAMBLE_RESET);
        random_traffic(70);

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/qpbe_pkg.sv
rtl/qpbe_cell.sv
rtl/qpbe_chain.sv
rtl/qi_packet_biphase_encoder.sv
test/qi_packet_biphase_encoder_tb.sv
